// File: rtl/core/pac_pkg.sv
// pac_pkg: shared constants and types for the premultiplied-alpha converter.
// Used by pac_lane, pac_merge and premultiplied_alpha_converter_core.
// No dependencies.
package pac_pkg;

  // Pixel geometry
  localparam int LANES    = 3;                 // red, green, blue
  localparam int CHAN_W   = 16;                // channel field width
  localparam int BYTE_W   = 8;                 // straight channel width
  localparam int WGT_W    = BYTE_W + 1;        // weight A8 + 1, 1..256
  localparam int QUO_BITS = BYTE_W;            // quotient bits kept after saturation
  localparam int DIV_W    = CHAN_W + 1;        // compare width for shifted divisor
  localparam int CHAN_MAX = 255;

  // Lane pipeline: one setup stage plus one stage per quotient bit
  localparam int PIPE_DEPTH = QUO_BITS + 1;
  // Start accepted to result strobe, including the output register
  localparam int LATENCY    = PIPE_DEPTH + 1;

  // Lane indexes
  localparam int LANE_RED   = 0;
  localparam int LANE_GREEN = 1;
  localparam int LANE_BLUE  = 2;

  typedef enum logic {
    MODE_PREMUL   = 1'b0,
    MODE_UNPREMUL = 1'b1
  } mode_t;

  // Sideband that travels next to the lanes
  typedef struct packed {
    logic              run_end;
    logic [CHAN_W-1:0] alpha;
  } ctrl_t;

  // One lane's finished channel
  typedef struct packed {
    logic [CHAN_W-1:0] value;
    logic              clip;
  } lane_res_t;

endpackage

// File: rtl/core/pac_lane.sv
// pac_lane: one colour channel. Premultiply by one 8x9 multiply, or
// unpremultiply by a restoring divider pipelined one quotient bit per stage.
// Depends on pac_pkg.
module pac_lane (
  input  logic                            clk,
  input  pac_pkg::mode_t                  mode_i,
  input  logic [pac_pkg::CHAN_W-1:0]      chan_i,
  input  logic [pac_pkg::WGT_W-1:0]       wgt_i,
  output pac_pkg::lane_res_t              res_o
);

  localparam int Q = pac_pkg::QUO_BITS;

  pac_pkg::mode_t                mode_r [0:Q];
  logic                          ovf_r  [0:Q];
  logic [pac_pkg::WGT_W-1:0]     wgt_r  [0:Q];
  logic [pac_pkg::CHAN_W-1:0]    rem_r  [0:Q];
  logic [Q-1:0]                  quo_r  [0:Q];

  logic [pac_pkg::CHAN_W-1:0]    rem_nxt [1:Q];
  logic [Q-1:0]                  quo_nxt [1:Q];
  logic [pac_pkg::DIV_W-1:0]     dvs     [1:Q];

  logic [pac_pkg::DIV_W-1:0]     prod;
  logic [pac_pkg::CHAN_W-1:0]    rem0_nxt;
  logic                          ovf0_nxt;

  // Setup stage: product for premultiply, overflow check for unpremultiply.
  // Quotient exceeds 255 exactly when C16 >= 256 * w.
  always_comb begin
    prod     = pac_pkg::DIV_W'(chan_i[pac_pkg::BYTE_W-1:0]) * pac_pkg::DIV_W'(wgt_i);
    ovf0_nxt = (mode_i == pac_pkg::MODE_UNPREMUL) &&
               ({1'b0, chan_i} >= {wgt_i, pac_pkg::BYTE_W'(0)});
    rem0_nxt = (mode_i == pac_pkg::MODE_PREMUL) ? prod[pac_pkg::CHAN_W-1:0] : chan_i;
  end

  // Divider stages: stage s settles quotient bit Q-s
  always_comb begin
    for (int s = 1; s <= Q; s++) begin
      dvs[s]     = pac_pkg::DIV_W'(wgt_r[s-1]) << (Q - s);
      rem_nxt[s] = rem_r[s-1];
      quo_nxt[s] = quo_r[s-1];
      if (mode_r[s-1] == pac_pkg::MODE_UNPREMUL && !ovf_r[s-1] &&
          {1'b0, rem_r[s-1]} >= dvs[s]) begin
        rem_nxt[s]        = rem_r[s-1] - dvs[s][pac_pkg::CHAN_W-1:0];
        quo_nxt[s][Q - s] = 1'b1;
      end
    end
  end

  // Pipeline registers (payload only, no reset)
  always_ff @(posedge clk) begin
    mode_r[0] <= mode_i;
    ovf_r[0]  <= ovf0_nxt;
    wgt_r[0]  <= wgt_i;
    rem_r[0]  <= rem0_nxt;
    quo_r[0]  <= '0;
    for (int s = 1; s <= Q; s++) begin
      mode_r[s] <= mode_r[s-1];
      ovf_r[s]  <= ovf_r[s-1];
      wgt_r[s]  <= wgt_r[s-1];
      rem_r[s]  <= rem_nxt[s];
      quo_r[s]  <= quo_nxt[s];
    end
  end

  // Final channel value with saturation
  always_comb begin
    res_o.clip = (mode_r[Q] == pac_pkg::MODE_UNPREMUL) && ovf_r[Q];
    if (mode_r[Q] == pac_pkg::MODE_PREMUL) begin
      res_o.value = rem_r[Q];
    end else if (ovf_r[Q]) begin
      res_o.value = pac_pkg::CHAN_W'(pac_pkg::CHAN_MAX);
    end else begin
      res_o.value = pac_pkg::CHAN_W'(quo_r[Q]);
    end
  end

endmodule

// File: rtl/core/pac_merge.sv
// pac_merge: joins the three lane results with the sideband into one
// registered result transaction and ORs the lane clip flags.
// Depends on pac_pkg.
module pac_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          valid_i,
  input  pac_pkg::ctrl_t                ctrl_i,
  input  pac_pkg::lane_res_t            res_i [pac_pkg::LANES],
  output logic                          valid_o,
  output logic [pac_pkg::CHAN_W-1:0]    red_o,
  output logic [pac_pkg::CHAN_W-1:0]    green_o,
  output logic [pac_pkg::CHAN_W-1:0]    blue_o,
  output logic [pac_pkg::CHAN_W-1:0]    alpha_o,
  output logic                          clip_o,
  output logic                          run_end_o
);

  logic                       valid_r;
  logic [pac_pkg::CHAN_W-1:0] red_r, green_r, blue_r, alpha_r;
  logic                       clip_r, run_end_r;
  logic                       clip_nxt;

  // Any saturated lane flags the pixel
  always_comb begin
    clip_nxt = 1'b0;
    for (int l = 0; l < pac_pkg::LANES; l++) begin
      clip_nxt = clip_nxt | res_i[l].clip;
    end
  end

  // Strobe register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    red_r     <= res_i[pac_pkg::LANE_RED].value;
    green_r   <= res_i[pac_pkg::LANE_GREEN].value;
    blue_r    <= res_i[pac_pkg::LANE_BLUE].value;
    alpha_r   <= ctrl_i.alpha;
    clip_r    <= clip_nxt;
    run_end_r <= ctrl_i.run_end;
  end

  assign valid_o   = valid_r;
  assign red_o     = red_r;
  assign green_o   = green_r;
  assign blue_o    = blue_r;
  assign alpha_o   = alpha_r;
  assign clip_o    = clip_r;
  assign run_end_o = run_end_r;

endmodule

// File: rtl/core/premultiplied_alpha_converter_core.sv
// premultiplied_alpha_converter_core: top level of the RGBA alpha converter.
// Instantiates three pac_lane channels and pac_merge; depends on pac_pkg.
//
// Usage:
//   Input channel: a transaction is taken at a rising edge with start high
//   and busy low. busy is always low, so one pixel may enter every cycle.
//   in_mode selects premultiply (8-bit straight to 16-bit premultiplied)
//   or unpremultiply (16-bit premultiplied to 8-bit straight, saturating).
//   Result channel: each result is on the out_ ports for one cycle, marked
//   by out_valid. Results leave in input order, one per transaction.
//   Path: an accepted pixel passes one setup stage, eight divider stages
//   and one output register before its result reaches the out_ ports.
//   Throughput: one pixel per cycle; each lane's divider is pipelined one
//   quotient bit per stage, so every stage holds a different pixel.
//   Reset (rst_n low, synchronous) clears the valid bits of the pipeline;
//   transactions in flight are dropped. The receiver cannot stall, so no
//   backpressure path exists and results are never held.
module premultiplied_alpha_converter_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_mode,
  input  logic [pac_pkg::CHAN_W-1:0]  in_red_in,
  input  logic [pac_pkg::CHAN_W-1:0]  in_green_in,
  input  logic [pac_pkg::CHAN_W-1:0]  in_blue_in,
  input  logic [pac_pkg::CHAN_W-1:0]  in_alpha_in,
  input  logic                        in_run_end,
  output logic                        out_valid,
  output logic [pac_pkg::CHAN_W-1:0]  out_red_out,
  output logic [pac_pkg::CHAN_W-1:0]  out_green_out,
  output logic [pac_pkg::CHAN_W-1:0]  out_blue_out,
  output logic [pac_pkg::CHAN_W-1:0]  out_alpha_out,
  output logic                        out_clipped,
  output logic                        out_run_end_out
);

  localparam int D = pac_pkg::PIPE_DEPTH;

  pac_pkg::mode_t              mode;
  logic [pac_pkg::WGT_W-1:0]   wgt;
  logic [pac_pkg::DIV_W-1:0]   alpha_pm;
  pac_pkg::ctrl_t              ctrl_nxt;
  logic                        accept;

  logic                        vld_r  [0:D-1];
  pac_pkg::ctrl_t              ctrl_r [0:D-1];

  pac_pkg::lane_res_t          lane_res [pac_pkg::LANES];
  logic [pac_pkg::CHAN_W-1:0]  lane_chan [pac_pkg::LANES];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Weight w = A8 + 1; A8 is the low byte in premultiply, the high byte otherwise
  always_comb begin
    mode = pac_pkg::mode_t'(in_mode);
    if (mode == pac_pkg::MODE_PREMUL) begin
      wgt = pac_pkg::WGT_W'(in_alpha_in[pac_pkg::BYTE_W-1:0]) + pac_pkg::WGT_W'(1);
    end else begin
      wgt = pac_pkg::WGT_W'(in_alpha_in[pac_pkg::CHAN_W-1:pac_pkg::BYTE_W]) +
            pac_pkg::WGT_W'(1);
    end
    // 255 * w as (w << 8) - w
    alpha_pm = {wgt, pac_pkg::BYTE_W'(0)} - pac_pkg::DIV_W'(wgt);
    ctrl_nxt.run_end = in_run_end;
    ctrl_nxt.alpha   = (mode == pac_pkg::MODE_PREMUL) ?
                       alpha_pm[pac_pkg::CHAN_W-1:0] :
                       pac_pkg::CHAN_W'(in_alpha_in[pac_pkg::CHAN_W-1:pac_pkg::BYTE_W]);
  end

  // Valid bits track transactions through the lane pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < D; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else begin
      vld_r[0] <= accept;
      for (int s = 1; s < D; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  // Sideband shift line, aligned with the lanes
  always_ff @(posedge clk) begin
    ctrl_r[0] <= ctrl_nxt;
    for (int s = 1; s < D; s++) begin
      ctrl_r[s] <= ctrl_r[s-1];
    end
  end

  assign lane_chan[pac_pkg::LANE_RED]   = in_red_in;
  assign lane_chan[pac_pkg::LANE_GREEN] = in_green_in;
  assign lane_chan[pac_pkg::LANE_BLUE]  = in_blue_in;

  // Colour lanes
  for (genvar l = 0; l < pac_pkg::LANES; l++) begin : g_lane
    pac_lane u_lane (
      .clk    (clk),
      .mode_i (mode),
      .chan_i (lane_chan[l]),
      .wgt_i  (wgt),
      .res_o  (lane_res[l])
    );
  end

  // Merge and output register
  pac_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (vld_r[D-1]),
    .ctrl_i    (ctrl_r[D-1]),
    .res_i     (lane_res),
    .valid_o   (out_valid),
    .red_o     (out_red_out),
    .green_o   (out_green_out),
    .blue_o    (out_blue_out),
    .alpha_o   (out_alpha_out),
    .clip_o    (out_clipped),
    .run_end_o (out_run_end_out)
  );

  // A result strobe always traces back to an earlier start
  a_strobe_has_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, pac_pkg::LATENCY))
    else $error("result strobe without matching start");

  // Clipping needs C16 >= 256 * (A8 + 1), impossible when A8 is 255
  a_clip_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |->
      out_alpha_out < pac_pkg::CHAN_W'(pac_pkg::CHAN_MAX))
    else $error("clipped result with full alpha");

  // A clipped pixel has at least one colour saturated
  a_clip_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |->
      out_red_out == pac_pkg::CHAN_W'(pac_pkg::CHAN_MAX) ||
      out_green_out == pac_pkg::CHAN_W'(pac_pkg::CHAN_MAX) ||
      out_blue_out == pac_pkg::CHAN_W'(pac_pkg::CHAN_MAX))
    else $error("clipped result without saturated colour");

endmodule

// File: verif/pixel_conversion_checker.sv
// pixel_conversion_checker: watches both channels of the alpha converter, predicts each
// pixel's conversion and compares it with what the block returns.
// Depends on pac_pkg for the mode encoding and channel widths.
module pixel_conversion_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       in_mode,
  input  logic [pac_pkg::CHAN_W-1:0] in_red_in,
  input  logic [pac_pkg::CHAN_W-1:0] in_green_in,
  input  logic [pac_pkg::CHAN_W-1:0] in_blue_in,
  input  logic [pac_pkg::CHAN_W-1:0] in_alpha_in,
  input  logic                       in_run_end,
  input  logic                       out_valid,
  input  logic [pac_pkg::CHAN_W-1:0] out_red_out,
  input  logic [pac_pkg::CHAN_W-1:0] out_green_out,
  input  logic [pac_pkg::CHAN_W-1:0] out_blue_out,
  input  logic [pac_pkg::CHAN_W-1:0] out_alpha_out,
  input  logic                       out_clipped,
  input  logic                       out_run_end_out,
  output int                         mismatch_count,
  output int                         pixels_pending,
  output int                         pixels_checked,
  output int                         saturated_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [pac_pkg::CHAN_W-1:0] red;
    logic [pac_pkg::CHAN_W-1:0] green;
    logic [pac_pkg::CHAN_W-1:0] blue;
    logic [pac_pkg::CHAN_W-1:0] alpha;
    logic                       clipped;
    logic                       run_end;
  } converted_pixel_t;

  converted_pixel_t converted_q[$];
  int               errors;
  int               checked;
  int               saturated;

  assign mismatch_count = errors;
  assign pixels_checked = checked;
  assign saturated_seen = saturated;

  // Premultiplied channel divided by the weight, saturated to one byte
  function automatic logic [pac_pkg::CHAN_W-1:0] straight_channel(
      logic [pac_pkg::CHAN_W-1:0] chan, logic [pac_pkg::WGT_W-1:0] weight, ref logic sat);
    logic [pac_pkg::CHAN_W-1:0] quot;
    quot = chan / pac_pkg::CHAN_W'(weight);
    if (quot > pac_pkg::CHAN_W'(pac_pkg::CHAN_MAX)) begin
      sat  = 1'b1;
      quot = pac_pkg::CHAN_W'(pac_pkg::CHAN_MAX);
    end
    return quot;
  endfunction

  // Expected result for one pixel transaction
  function automatic converted_pixel_t convert_pixel(pac_pkg::mode_t mode,
                                                     logic [pac_pkg::CHAN_W-1:0] red,
                                                     logic [pac_pkg::CHAN_W-1:0] green,
                                                     logic [pac_pkg::CHAN_W-1:0] blue,
                                                     logic [pac_pkg::CHAN_W-1:0] alpha,
                                                     logic run_end);
    converted_pixel_t              res;
    logic [pac_pkg::WGT_W-1:0]     weight;
    logic                          sat;
    sat = 1'b0;
    if (mode == pac_pkg::MODE_PREMUL) begin
      // weight from the low alpha byte; high bytes are don't-care
      weight    = pac_pkg::WGT_W'(alpha[pac_pkg::BYTE_W-1:0]) + pac_pkg::WGT_W'(1);
      res.red   = pac_pkg::CHAN_W'(red[pac_pkg::BYTE_W-1:0]) * pac_pkg::CHAN_W'(weight);
      res.green = pac_pkg::CHAN_W'(green[pac_pkg::BYTE_W-1:0]) * pac_pkg::CHAN_W'(weight);
      res.blue  = pac_pkg::CHAN_W'(blue[pac_pkg::BYTE_W-1:0]) * pac_pkg::CHAN_W'(weight);
      res.alpha = pac_pkg::CHAN_W'(pac_pkg::CHAN_MAX) * pac_pkg::CHAN_W'(weight);
    end else begin
      // weight from the high alpha byte, never zero
      weight    = pac_pkg::WGT_W'(alpha[pac_pkg::CHAN_W-1:pac_pkg::BYTE_W]) +
                  pac_pkg::WGT_W'(1);
      res.red   = straight_channel(red, weight, sat);
      res.green = straight_channel(green, weight, sat);
      res.blue  = straight_channel(blue, weight, sat);
      res.alpha = pac_pkg::CHAN_W'(alpha[pac_pkg::CHAN_W-1:pac_pkg::BYTE_W]);
    end
    res.clipped = sat;
    res.run_end = run_end;
    return res;
  endfunction

  task automatic compare_field(string field, logic [pac_pkg::CHAN_W-1:0] expected,
                               logic [pac_pkg::CHAN_W-1:0] actual);
    if (actual !== expected) begin
      $error("%s mismatch: expected 0x%04h, got 0x%04h", field, expected, actual);
      errors++;
    end
  endtask

  // Record accepted pixels, check each result against the oldest prediction
  always @(posedge clk) begin
    converted_pixel_t want;
    if (!rst_n) begin
      converted_q.delete();
    end else begin
      if (start && !busy)
        converted_q.push_back(convert_pixel(pac_pkg::mode_t'(in_mode), in_red_in,
                                            in_green_in, in_blue_in, in_alpha_in,
                                            in_run_end));
      if (out_valid) begin
        if (converted_q.size() == 0) begin
          $error("result with no pixel outstanding");
          errors++;
        end else begin
          want = converted_q.pop_front();
          checked++;
          if (want.clipped)
            saturated++;
          compare_field("red_out", want.red, out_red_out);
          compare_field("green_out", want.green, out_green_out);
          compare_field("blue_out", want.blue, out_blue_out);
          compare_field("alpha_out", want.alpha, out_alpha_out);
          compare_field("clipped", pac_pkg::CHAN_W'(want.clipped),
                        pac_pkg::CHAN_W'(out_clipped));
          compare_field("run_end_out", pac_pkg::CHAN_W'(want.run_end),
                        pac_pkg::CHAN_W'(out_run_end_out));
        end
      end
    end
    pixels_pending <= converted_q.size();
  end

  initial begin
    errors    = 0;
    checked   = 0;
    saturated = 0;
  end

endmodule

// File: verif/premultiplied_alpha_converter_core_tb.sv
// premultiplied_alpha_converter_core_tb: drives directed and random pixels into the
// alpha converter and reports the verdict; checking lives in pixel_conversion_checker.
// Depends on pac_pkg, the converter RTL and pixel_conversion_checker.
module premultiplied_alpha_converter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PIXELS = 1750;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int CW            = pac_pkg::CHAN_W;
  localparam int BW            = pac_pkg::BYTE_W;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          start;
  logic          busy;
  logic          in_mode;
  logic [CW-1:0] in_red_in;
  logic [CW-1:0] in_green_in;
  logic [CW-1:0] in_blue_in;
  logic [CW-1:0] in_alpha_in;
  logic          in_run_end;
  logic          out_valid;
  logic [CW-1:0] out_red_out;
  logic [CW-1:0] out_green_out;
  logic [CW-1:0] out_blue_out;
  logic [CW-1:0] out_alpha_out;
  logic          out_clipped;
  logic          out_run_end_out;

  int mismatch_count;
  int pixels_pending;
  int pixels_checked;
  int saturated_seen;
  int premul_sent;
  int unpremul_sent;
  int max_gap;

  always #5 clk = ~clk;

  premultiplied_alpha_converter_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .in_alpha_in    (in_alpha_in),
    .in_run_end     (in_run_end),
    .out_valid      (out_valid),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out),
    .out_alpha_out  (out_alpha_out),
    .out_clipped    (out_clipped),
    .out_run_end_out(out_run_end_out)
  );

  pixel_conversion_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .in_alpha_in    (in_alpha_in),
    .in_run_end     (in_run_end),
    .out_valid      (out_valid),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out),
    .out_alpha_out  (out_alpha_out),
    .out_clipped    (out_clipped),
    .out_run_end_out(out_run_end_out),
    .mismatch_count (mismatch_count),
    .pixels_pending (pixels_pending),
    .pixels_checked (pixels_checked),
    .saturated_seen (saturated_seen)
  );

  // One pixel transaction, then a random idle gap bounded by max_gap
  task automatic send_pixel(pac_pkg::mode_t mode, logic [CW-1:0] red,
                            logic [CW-1:0] green, logic [CW-1:0] blue,
                            logic [CW-1:0] alpha, logic run_end);
    int gap;
    gap         = $urandom_range(0, max_gap);
    start       <= 1'b1;
    in_mode     <= mode;
    in_red_in   <= red;
    in_green_in <= green;
    in_blue_in  <= blue;
    in_alpha_in <= alpha;
    in_run_end  <= run_end;
    do @(posedge clk); while (busy);
    if (mode == pac_pkg::MODE_PREMUL)
      premul_sent++;
    else
      unpremul_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Premultiplied channel for a given weight: mostly in range, some near or past saturation
  function automatic logic [CW-1:0] pick_premul_channel(int weight);
    int roll;
    int top;
    roll = $urandom_range(0, 99);
    top  = (256 * weight + weight > 65535) ? 65535 : 256 * weight + weight;
    if (roll < 70)
      return CW'($urandom_range(0, 256 * weight - 1));
    else if (roll < 85)
      return CW'($urandom_range(255 * weight, top));
    else
      return CW'($urandom);
  endfunction

  // Random pixel: straight pixels with junk high bytes, or premultiplied ones
  task automatic send_random_pixel();
    logic [CW-1:0] alpha;
    logic          run_end;
    int            roll;
    alpha   = CW'($urandom);
    run_end = ($urandom_range(0, 15) == 0);
    roll    = $urandom_range(0, 9);
    if ($urandom_range(0, 1) == 0) begin
      if (roll == 0)
        alpha[BW-1:0] = '0;
      else if (roll == 1)
        alpha[BW-1:0] = '1;
      send_pixel(pac_pkg::MODE_PREMUL, CW'($urandom), CW'($urandom), CW'($urandom),
                 alpha, run_end);
    end else begin
      if (roll == 0)
        alpha[CW-1:BW] = '0;
      else if (roll == 1)
        alpha[CW-1:BW] = '1;
      send_pixel(pac_pkg::MODE_UNPREMUL, pick_premul_channel(alpha[CW-1:BW] + 1),
                 pick_premul_channel(alpha[CW-1:BW] + 1),
                 pick_premul_channel(alpha[CW-1:BW] + 1), alpha, run_end);
    end
  endtask

  // Run limit
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    int waited;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_mode       = pac_pkg::MODE_PREMUL;
    in_red_in     = '0;
    in_green_in   = '0;
    in_blue_in    = '0;
    in_alpha_in   = '0;
    in_run_end    = 1'b0;
    premul_sent   = 0;
    unpremul_sent = 0;
    max_gap       = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: straight to premultiplied extremes, high bytes ignored
    send_pixel(pac_pkg::MODE_PREMUL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_pixel(pac_pkg::MODE_PREMUL, 16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF, 1'b1);
    send_pixel(pac_pkg::MODE_PREMUL, 16'h00FF, 16'h0080, 16'h0001, 16'h0000, 1'b0);
    send_pixel(pac_pkg::MODE_PREMUL, 16'hFFFF, 16'hFF00, 16'hAB12, 16'hFF7F, 1'b1);
    send_pixel(pac_pkg::MODE_PREMUL, 16'hFF01, 16'h0002, 16'h8003, 16'hFF00, 1'b0);
    send_pixel(pac_pkg::MODE_PREMUL, 16'h5A5A, 16'hA5A5, 16'h00C3, 16'h0080, 1'b0);
    // Directed: premultiplied to straight, including saturation and zero alpha
    send_pixel(pac_pkg::MODE_UNPREMUL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_pixel(pac_pkg::MODE_UNPREMUL, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_pixel(pac_pkg::MODE_UNPREMUL, 16'h00FF, 16'h0100, 16'h0000, 16'h00FF, 1'b0);
    send_pixel(pac_pkg::MODE_UNPREMUL, 16'h8000, 16'h7FFF, 16'h0100, 16'h7F00, 1'b0);
    send_pixel(pac_pkg::MODE_UNPREMUL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_pixel(pac_pkg::MODE_UNPREMUL, 16'hFF00, 16'hFEFF, 16'h0064, 16'hFF12, 1'b0);
    send_pixel(pac_pkg::MODE_UNPREMUL, 16'h00FE, 16'h00FF, 16'hFFFF, 16'h00A5, 1'b0);
    send_pixel(pac_pkg::MODE_UNPREMUL, 16'h1234, 16'h5678, 16'h9ABC, 16'h8034, 1'b1);
    send_pixel(pac_pkg::MODE_UNPREMUL, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b0);

    // Random: each block of 64 pixels is picked at random as back-to-back or randomly gapped
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i % 64 == 0)
        max_gap = ($urandom_range(0, 2) == 0) ? 0 : 7;
      if (i == RANDOM_PIXELS / 2) begin
        // hold the input until the pipeline has emptied
        start <= 1'b0;
        @(posedge clk);
        while (pixels_pending != 0)
          @(posedge clk);
      end
      send_random_pixel();
    end
    start <= 1'b0;

    // Drain the pipeline, then allow for the block's latency
    waited = 0;
    while (pixels_pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * pac_pkg::LATENCY) @(posedge clk);
    if (pixels_pending != 0)
      $error("%0d pixels never produced a result", pixels_pending);

    $display("Sent %0d straight and %0d premultiplied pixels, directed extremes first.",
             premul_sent, unpremul_sent);
    $display("Checked %0d results, %0d of them saturated.", pixels_checked, saturated_seen);
    if (mismatch_count == 0 && pixels_pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
